[rtl/rhc_pkg.sv]
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the rgb to hsl converter
// Channel widths, lane numbering of the divider chain and the fixed
// angles and scales of the hsl conversion.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int HUE_FRAC_BITS_DEF  = 6;
	localparam int UNIT_FRAC_BITS_DEF = 16;

	localparam int CH_W  = 8;   // one color channel
	localparam int REM_W = 9;   // partial remainder, holds any divisor up to 510

	// divider lanes that travel together down the chain
	localparam int LANES      = 2;
	localparam int LANE_HUE   = 0;
	localparam int LANE_SAT   = 1;

	localparam int CH_MAX     = 255;
	localparam int LIGHT_DIV  = 2 * CH_MAX;
	localparam int DEG_SECTOR = 60;
	localparam int DEG_FULL   = 360;

	// lightness is sum * 2^(UNIT_FRAC_BITS-1) / 255 by reciprocal multiply;
	// 17 extra fraction bits keep the error below 1/255 for any sum up to 510
	localparam int LIGHT_SHIFT = 17;

	typedef struct packed {
		logic            valid;
		logic            gray;
		logic [CH_W:0]   sum;
	} ctl_t;

endpackage

[rtl/rhc_front.sv]
// ----------------------------------------------------------------------------
// rhc_front: pixel front end
// Finds max, min, chroma and sum of a pixel, loads the hue and saturation
// divider lanes with remainder, numerator and divisor and passes the sum on.
// ----------------------------------------------------------------------------
module rhc_front #(
	parameter int HUE_FRAC_BITS  = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int UNIT_FRAC_BITS = rhc_pkg::UNIT_FRAC_BITS_DEF,
	parameter int STEPS          = 17
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              take,
	input  logic [rhc_pkg::CH_W-1:0]                          red,
	input  logic [rhc_pkg::CH_W-1:0]                          green,
	input  logic [rhc_pkg::CH_W-1:0]                          blue,
	output rhc_pkg::ctl_t                                     ctl_s1,
	output logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0]     rem_s1,
	output logic [rhc_pkg::LANES-1:0][STEPS-1:0]              quo_s1,
	output logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0]     div_s1
);
	import rhc_pkg::*;

	localparam int XW = STEPS + REM_W;

	logic [CH_W-1:0]     mx;
	logic [CH_W-1:0]     mn;
	logic [CH_W-1:0]     chroma;
	logic [CH_W:0]       sum;
	logic [REM_W-1:0]    denom;
	logic signed [18:0]  num_red;
	logic signed [18:0]  num;
	logic [XW-1:0]       x_hue;
	logic [XW-1:0]       x_sat;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		chroma = mx - mn;
		sum    = {1'b0, mx} + {1'b0, mn};
		denom  = (sum <= 9'(CH_MAX)) ? sum : 9'(LIGHT_DIV) - sum;

		// sector of the largest channel, red wins ties over green, green over blue
		num_red = 19'(DEG_SECTOR) * ($signed({11'd0, green}) - $signed({11'd0, blue}));
		if (mx == red) begin
			num = num_red;
			if (num_red < 0) num = num_red + 19'(DEG_FULL) * $signed({11'd0, chroma});
		end else if (mx == green) begin
			num = 19'(2 * DEG_SECTOR) * $signed({11'd0, chroma})
				+ 19'(DEG_SECTOR) * ($signed({11'd0, blue}) - $signed({11'd0, red}));
		end else begin
			num = 19'(4 * DEG_SECTOR) * $signed({11'd0, chroma})
				+ 19'(DEG_SECTOR) * ($signed({11'd0, red}) - $signed({11'd0, green}));
		end

		x_hue   = XW'(num[16:0]) << HUE_FRAC_BITS;
		x_sat   = XW'(chroma) << UNIT_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= take;
			ctl_s1.gray  <= (chroma == '0);
			ctl_s1.sum   <= sum;
		end
	end

	// quotient fits in STEPS bits, so the bits above them start as the remainder
	always_ff @(posedge clk) begin
		rem_s1[LANE_HUE]     <= x_hue[XW-1:STEPS];
		rem_s1[LANE_SAT]     <= x_sat[XW-1:STEPS];
		quo_s1[LANE_HUE]     <= x_hue[STEPS-1:0];
		quo_s1[LANE_SAT]     <= x_sat[STEPS-1:0];
		div_s1[LANE_HUE]     <= {1'b0, chroma};
		div_s1[LANE_SAT]     <= denom;
	end

endmodule

[rtl/rhc_cell.sv]
// ----------------------------------------------------------------------------
// rhc_cell: one restoring division step for both lanes
// Shifts the next numerator bit into the remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the low end of the word.
// ----------------------------------------------------------------------------
module rhc_cell #(
	parameter int STEPS = 17
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  rhc_pkg::ctl_t                                 ctl_i,
	input  logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0] rem_i,
	input  logic [rhc_pkg::LANES-1:0][STEPS-1:0]          quo_i,
	input  logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0] div_i,
	output rhc_pkg::ctl_t                                 ctl_q,
	output logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0] rem_q,
	output logic [rhc_pkg::LANES-1:0][STEPS-1:0]          quo_q,
	output logic [rhc_pkg::LANES-1:0][rhc_pkg::REM_W-1:0] div_q
);
	import rhc_pkg::*;

	logic [LANES-1:0][REM_W:0]     trial;
	logic [LANES-1:0]              fits;
	logic [LANES-1:0][REM_W-1:0]   rem_n;
	logic [LANES-1:0][STEPS-1:0]   quo_n;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {rem_i[l], quo_i[l][STEPS-1]};
			fits[l]  = (trial[l] >= {1'b0, div_i[l]});
			rem_n[l] = fits[l] ? REM_W'(trial[l] - {1'b0, div_i[l]}) : trial[l][REM_W-1:0];
			quo_n[l] = {quo_i[l][STEPS-2:0], fits[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q      <= rem_n;
		quo_q      <= quo_n;
		div_q      <= div_i;
	end

endmodule

[rtl/rgb_to_hsl_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter: pipelined rgb to hsl color conversion
// Converts one 8-bit rgb pixel per clock into hue, saturation, lightness.
// ----------------------------------------------------------------------------
// usage:
//   a pixel beat on red/green/blue is taken at a clock edge with start high
//   and busy low; busy never rises, so a new pixel may come every cycle
//   the result beat shows on hue/saturation/lightness for one cycle with done
//   high, in the order the pixels came in; the receiver cannot stall it
//   a pixel is registered in the front stage and then in each division cell;
//   the outputs are combinational from the last cell
//   throughput is one pixel per cycle: a front stage finds max/min/chroma and
//   loads a row of division cells, one quotient bit per cell, with the hue
//   and saturation quotients moving side by side; the pixel sum rides along
//   and lightness comes from it by a reciprocal multiply at the output
//   hue is in 1/2^HUE_FRAC_BITS degree, saturation and lightness are unsigned
//   Q1.UNIT_FRAC_BITS; gray pixels give hue 0 and saturation 0
//   reset clears the valid flags of all stages, dropping beats in flight;
//   the datapath registers are not reset and keep their state
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
	parameter int HUE_FRAC_BITS  = rhc_pkg::HUE_FRAC_BITS_DEF,
	parameter int UNIT_FRAC_BITS = rhc_pkg::UNIT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rhc_pkg::CH_W-1:0]      red,
	input  logic [rhc_pkg::CH_W-1:0]      green,
	input  logic [rhc_pkg::CH_W-1:0]      blue,
	output logic                          done,
	output logic [HUE_FRAC_BITS+8:0]      hue,
	output logic [UNIT_FRAC_BITS:0]       saturation,
	output logic [UNIT_FRAC_BITS:0]       lightness
);
	import rhc_pkg::*;

	localparam int HUE_W   = HUE_FRAC_BITS + 9;
	localparam int UNIT_W  = UNIT_FRAC_BITS + 1;
	localparam int STEPS   = (HUE_W > UNIT_W) ? HUE_W : UNIT_W;
	localparam int LAT     = STEPS + 1;

	localparam int LMUL_W  = UNIT_FRAC_BITS + 9;
	localparam int PROD_W  = LMUL_W + CH_W + 1;
	localparam logic [LMUL_W-1:0] LIGHT_MUL =
		LMUL_W'(((64'd1 << (UNIT_FRAC_BITS - 1 + LIGHT_SHIFT)) + 64'd254) / 64'd255);

	ctl_t                               ctl [STEPS+1];
	logic [LANES-1:0][REM_W-1:0]        rem [STEPS+1];
	logic [LANES-1:0][STEPS-1:0]        quo [STEPS+1];
	logic [LANES-1:0][REM_W-1:0]        dvs [STEPS+1];
	logic [PROD_W-1:0]                  light_prod;

	assign busy = 1'b0;

	rhc_front #(
		.HUE_FRAC_BITS  (HUE_FRAC_BITS),
		.UNIT_FRAC_BITS (UNIT_FRAC_BITS),
		.STEPS          (STEPS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.ctl_s1 (ctl[0]),
		.rem_s1 (rem[0]),
		.quo_s1 (quo[0]),
		.div_s1 (dvs[0])
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		rhc_cell #(
			.STEPS (STEPS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl[k]),
			.rem_i  (rem[k]),
			.quo_i  (quo[k]),
			.div_i  (dvs[k]),
			.ctl_q  (ctl[k+1]),
			.rem_q  (rem[k+1]),
			.quo_q  (quo[k+1]),
			.div_q  (dvs[k+1])
		);
	end

	// sum / 510 as sum times a rounded-up reciprocal of 255
	assign light_prod = PROD_W'(ctl[STEPS].sum) * PROD_W'(LIGHT_MUL);

	// gray pixels divide by zero in the hue lane, so both fields are forced
	assign done       = ctl[STEPS].valid;
	assign hue        = ctl[STEPS].gray ? '0 : quo[STEPS][LANE_HUE][HUE_W-1:0];
	assign saturation = ctl[STEPS].gray ? '0 : quo[STEPS][LANE_SAT][UNIT_W-1:0];
	assign lightness  = light_prod[LIGHT_SHIFT +: UNIT_W];

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted pixel did not produce a result beat");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue < HUE_W'(DEG_FULL << HUE_FRAC_BITS))
		else $error("hue at or above full turn");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (saturation <= UNIT_W'(1 << UNIT_FRAC_BITS))
			&& (lightness <= UNIT_W'(1 << UNIT_FRAC_BITS)))
		else $error("saturation or lightness above one");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		done && (saturation == '0) |-> hue == '0)
		else $error("zero saturation with nonzero hue");
`endif

endmodule
